// ===== sv/mie_pkg.sv =====
package mie_pkg;

  // Default operand width of the block.
  localparam int unsigned MIE_WIDTH = 32;

  // Sequencer states of the Euclid engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } mie_state_t;

endpackage

// ===== sv/modular_inverse_ext_euclid_top.sv =====
// Channel    Direction  Payload (lowest bits first)                 Handshake
// s_axis     in         modulus, value                              tvalid / tready
// m_axis     out        inverse, divisor, bad_modulus               tvalid / tready
//
// An item runs k Euclid rounds, at most about 46 at 32 bits. Each round
// tests the divisor for zero, then runs a bit-serial restoring division,
// one quotient bit per cycle, then an update step. The quotient bits feed a
// double-and-add unit modulo the modulus in the same cycles, so the product
// of quotient and coefficient is ready when the division ends.
// Reset (rst, synchronous, active high) returns the engine to idle and
// drops any waiting result. A new item is taken as soon as the engine is
// idle, even while the previous result still waits in the output register.
module modular_inverse_ext_euclid_top #(
  parameter int unsigned WIDTH = mie_pkg::MIE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // s_axis_tdata: modulus [WIDTH-1:0], value [2*WIDTH-1:WIDTH], zero fill above
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((2*WIDTH+7)/8)*8-1:0]           s_axis_tdata,
  // m_axis_tdata: inverse [WIDTH-1:0], divisor [2*WIDTH-1:WIDTH],
  // bad_modulus [2*WIDTH], zero fill above
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((2*WIDTH+1+7)/8)*8-1:0]         m_axis_tdata
);

  import mie_pkg::*;

  localparam int unsigned CW      = $clog2(WIDTH);
  localparam int unsigned OUT_W   = ((2*WIDTH+1+7)/8)*8;
  localparam int unsigned OUT_PAD = OUT_W - (2*WIDTH+1);

  mie_state_t state, state_next;

  // Euclid remainders: a is the dividend (shifted out during a division),
  // b the divisor, rem the partial remainder.
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] rem;
  // Coefficients, kept reduced modulo the modulus, and the product unit.
  logic [WIDTH-1:0] mod;
  logic             ok;
  logic [WIDTH-1:0] c0;
  logic [WIDTH-1:0] c1;
  logic [WIDTH-1:0] acc;
  logic [CW-1:0]    cnt;

  // Output register.
  logic             out_valid;
  logic [WIDTH-1:0] out_inverse;
  logic [WIDTH-1:0] out_divisor;
  logic             out_bad;

  logic             in_fire;
  logic             out_load;

  // One restoring division step.
  logic [WIDTH:0]   rem_shift;
  logic             qbit;
  logic [WIDTH-1:0] rem_step;

  // One double-and-add step modulo the modulus: acc < mod and c1 < mod, so
  // the sum stays below three times the modulus.
  logic [WIDTH+1:0] dbl_sum;
  logic [WIDTH+1:0] mod_x1;
  logic [WIDTH+1:0] mod_x2;
  logic [WIDTH-1:0] acc_step;

  // New coefficient c0 - q * c1 modulo the modulus.
  logic [WIDTH-1:0] c_new;

  assign rem_shift = {rem, a[WIDTH-1]};
  assign qbit      = (rem_shift >= {1'b0, b});
  assign rem_step  = qbit ? WIDTH'(rem_shift - {1'b0, b}) : rem_shift[WIDTH-1:0];

  assign mod_x1  = {2'b00, mod};
  assign mod_x2  = {1'b0, mod, 1'b0};
  assign dbl_sum = {1'b0, acc, 1'b0} + (qbit ? {2'b00, c1} : '0);

  always_comb begin
    if (dbl_sum >= mod_x2) begin
      acc_step = WIDTH'(dbl_sum - mod_x2);
    end else if (dbl_sum >= mod_x1) begin
      acc_step = WIDTH'(dbl_sum - mod_x1);
    end else begin
      acc_step = dbl_sum[WIDTH-1:0];
    end
  end

  assign c_new = (c0 >= acc) ? (c0 - acc) : (c0 + (mod - acc));

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == ST_DONE) && (!out_valid || m_axis_tready);

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (b == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          a   <= s_axis_tdata[WIDTH-1:0];
          mod <= s_axis_tdata[WIDTH-1:0];
          b   <= s_axis_tdata[2*WIDTH-1:WIDTH];
          ok  <= (s_axis_tdata[WIDTH-1:0] != '0);
          c0  <= '0;
          // 1 mod m is zero only for a modulus of one.
          c1  <= (s_axis_tdata[WIDTH-1:0] == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
      end
      ST_CHECK: begin
        rem <= '0;
        acc <= '0;
        cnt <= CW'(WIDTH - 1);
      end
      ST_DIV: begin
        rem <= rem_step;
        a   <= {a[WIDTH-2:0], qbit};
        acc <= acc_step;
        cnt <= cnt - CW'(1);
      end
      ST_UPD: begin
        a <= b;
        b <= rem;
        if (ok) begin
          c0 <= c1;
          c1 <= c_new;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded while the previous result is taken or absent.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_inverse <= ok ? c0 : '0;
      out_divisor <= a;
      out_bad     <= !ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  generate
    if (OUT_PAD > 0) begin : g_pad
      assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_bad, out_divisor, out_inverse};
    end else begin : g_nopad
      assign m_axis_tdata = {out_bad, out_divisor, out_inverse};
    end
  endgenerate

  // The division never starts with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (b != '0))
    else $error("division running with zero divisor");

  // Coefficients and the product stay reduced below the modulus.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV || state == ST_UPD) && ok) |->
      (c0 < mod && c1 < mod && acc < mod))
    else $error("coefficient not reduced modulo the modulus");

  // A zero modulus always gives a zero inverse.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_bad) |-> (out_inverse == '0))
    else $error("nonzero inverse reported with zero modulus");

endmodule

// ===== verif/tb_modular_inverse_ext_euclid_top.sv =====
module tb_modular_inverse_ext_euclid_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mie_pkg::*;

  localparam int unsigned W = MIE_WIDTH;
  localparam int IN_BITS = ((2 * W + 7) / 8) * 8;
  localparam int OUT_BITS = ((2 * W + 1 + 7) / 8) * 8;

  // The slowest item needs about 46 Euclid rounds.
  localparam int SLOWEST_ITEM = 46 * (W + 2) + 3;
  localparam int TAIL_CYCLES = 2 * SLOWEST_ITEM;
  localparam int HOLD_CYCLES = 6000;
  localparam int HOLD_AT_FIRST = 120;
  localparam int HOLD_AT_SECOND = 1000;
  localparam int DRAIN_AT_FIRST = 600;
  localparam int DRAIN_AT_SECOND = 1200;
  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_REPORTS = 10;
  // Every item at its slowest plus both sides at their longest waits, taken
  // four times over, plus the two long receiver holds.
  localparam longint CYCLE_LIMIT =
    4 * (RANDOM_ITEMS + 25) * (SLOWEST_ITEM + 20) + 2 * HOLD_CYCLES;

  // One operand pair as queued for the sender, with its pacing.
  typedef struct {
    logic [W-1:0] modulus;
    logic [W-1:0] value;
    int           gap;
    bit           drain;
  } operand_t;

  // One result as the block should return it.
  typedef struct packed {
    logic         bad_modulus;
    logic [W-1:0] divisor;
    logic [W-1:0] inverse;
  } inv_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  operand_t    operand_q[$];
  inv_result_t awaited_results[$];
  operand_t    cur_item;
  bit          feeding = 1'b0;
  int          gap_left = 0;
  int          ready_wait = 0;
  int          results_seen = 0;
  int          err_cnt = 0;
  longint      cycle_cnt = 0;

  modular_inverse_ext_euclid_top #(
    .WIDTH(W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Extended Euclid with exact signed coefficients. The coefficient of the
  // value never exceeds the modulus in magnitude, so 64-bit arithmetic is
  // enough, and the final coefficient is brought into [0, modulus) at the end.
  function automatic inv_result_t predict_inverse(logic [W-1:0] m, logic [W-1:0] v);
    longint      mod_l;
    longint      r_prev;
    longint      r_cur;
    longint      r_next;
    longint      quot;
    longint      c_prev;
    longint      c_cur;
    longint      c_next;
    inv_result_t res;
    mod_l = m;
    r_prev = m;
    r_cur = v;
    c_prev = 0;
    c_cur = 1;
    while (r_cur != 0) begin
      quot = r_prev / r_cur;
      r_next = r_prev - quot * r_cur;
      c_next = c_prev - quot * c_cur;
      r_prev = r_cur;
      r_cur = r_next;
      c_prev = c_cur;
      c_cur = c_next;
    end
    res.divisor = r_prev[W-1:0];
    res.bad_modulus = (m == '0);
    if (m == '0) begin
      res.inverse = '0;
    end else begin
      c_prev = c_prev % mod_l;
      if (c_prev < 0) begin
        c_prev = c_prev + mod_l;
      end
      res.inverse = c_prev[W-1:0];
    end
    return res;
  endfunction

  // Sender. Each queued item first waits out its own gap; an item marked to
  // drain is held back until every result in flight has come out. The
  // prediction is made at the edge where the block accepts the item.
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      feeding = 1'b0;
      gap_left = 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(predict_inverse(cur_item.modulus, cur_item.value));
        next_valid = 1'b0;
        feeding = 1'b0;
      end
      if (!feeding && operand_q.size() != 0) begin
        cur_item = operand_q.pop_front();
        gap_left = cur_item.gap;
        feeding = 1'b1;
      end
      if (feeding && !next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(cur_item.drain && awaited_results.size() != 0)) begin
          next_valid = 1'b1;
          s_axis_tdata <= IN_BITS'({cur_item.value, cur_item.modulus});
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Receiver and checker. After each result the receiver draws how long it
  // keeps tready low. Every third run of fifty results it never waits, and at
  // two points it holds off long enough that the engine and its output
  // register both fill and the block stops taking items.
  always @(posedge clk) begin
    inv_result_t want;
    inv_result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.inverse = m_axis_tdata[W-1:0];
        got.divisor = m_axis_tdata[2*W-1:W];
        got.bad_modulus = m_axis_tdata[2*W];
        if (awaited_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] unexpected result: inverse %0d divisor %0d bad_modulus %0b",
                     $realtime, got.inverse, got.divisor, got.bad_modulus);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("[%0t] result %0d mismatch", $realtime, results_seen);
              $display("  inverse     expected %0d actual %0d", want.inverse, got.inverse);
              $display("  divisor     expected %0d actual %0d", want.divisor, got.divisor);
              $display("  bad_modulus expected %0b actual %0b",
                       want.bad_modulus, got.bad_modulus);
            end
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND) begin
          ready_wait = HOLD_CYCLES;
        end else if ((results_seen / 50) % 3 == 2) begin
          ready_wait = 0;
        end else begin
          ready_wait = $urandom_range(0, 8);
        end
      end
      if (ready_wait > 0) begin
        ready_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Queues one item; the sender gap is drawn here so that runs of items in
  // every third block of fifty go back to back.
  function automatic void queue_pair(logic [W-1:0] m, logic [W-1:0] v);
    operand_t op;
    op.modulus = m;
    op.value = v;
    op.gap = ((operand_q.size() / 50) % 3 == 1) ? 0 : $urandom_range(0, 8);
    op.drain = 1'b0;
    operand_q.push_back(op);
  endfunction

  initial begin
    longint       fib[0:47];
    int           total;
    int           kind;
    int           k;
    longint       g;
    longint       a;
    longint       b;
    logic [W-1:0] m;
    logic [W-1:0] v;

    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i <= 47; i++) begin
      fib[i] = fib[i-1] + fib[i-2];
    end

    // Directed items: zero modulus, zero value and both zero, modulus one,
    // all-ones operands, value above the modulus, pairs with no inverse, and
    // the consecutive Fibonacci pair that needs the most rounds.
    queue_pair('0, '0);
    queue_pair('0, 32'd1);
    queue_pair('0, '1);
    queue_pair(32'd1, '0);
    queue_pair(32'd1, 32'd5);
    queue_pair(32'd1, 32'd1);
    queue_pair('1, '0);
    queue_pair('1, '1);
    queue_pair('1, 32'd2);
    queue_pair(32'hFFFF_FFFB, 32'd3);
    queue_pair(32'd7, 32'd3);
    queue_pair(32'd10, 32'd4);
    queue_pair(32'd12, 32'd18);
    queue_pair(32'd2, 32'd1);
    queue_pair(32'd3, 32'd3);
    queue_pair(32'd5, '1);
    queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
    queue_pair(fib[47][W-1:0], fib[46][W-1:0]);
    queue_pair(fib[46][W-1:0], fib[47][W-1:0]);

    // Random items, weighted toward shapes that run many rounds or hit the
    // corners, with a share of small operands to keep the run short.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        m = $urandom;
        v = $urandom;
      end else if (kind < 50) begin
        m = $urandom;
        v = (m == '0) ? $urandom : $urandom % m;
      end else if (kind < 72) begin
        m = $urandom >> (W - $urandom_range(1, W));
        v = $urandom >> (W - $urandom_range(1, W));
      end else if (kind < 82) begin
        // A shared factor, so there is no inverse.
        g = $urandom_range(2, 1000);
        a = $urandom_range(1, 2000000);
        b = $urandom_range(0, 2000000);
        m = W'(g * a);
        v = W'(g * b);
      end else if (kind < 90) begin
        case ($urandom_range(0, 3))
          0: begin
            m = '0;
            v = $urandom;
          end
          1: begin
            m = 32'd1;
            v = $urandom;
          end
          2: begin
            m = $urandom;
            v = '0;
          end
          default: begin
            m = $urandom;
            v = m;
          end
        endcase
      end else if (kind < 95) begin
        k = $urandom_range(2, 46);
        m = fib[k+1][W-1:0];
        v = fib[k][W-1:0];
      end else begin
        v = $urandom | 32'h8000_0000;
        m = $urandom % v;
      end
      queue_pair(m, v);
    end

    // Twice the sender stops until every result in flight has come back.
    operand_q[DRAIN_AT_FIRST].drain = 1'b1;
    operand_q[DRAIN_AT_SECOND].drain = 1'b1;
    total = operand_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (operand_q.size() != 0 || feeding) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // Any stray result after the last expected one is caught by the checker.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && results_seen == total) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mie_pkg.sv
sv/modular_inverse_ext_euclid_top.sv
verif/tb_modular_inverse_ext_euclid_top.sv
